@@ hw/rtl/coi_pkg.sv @@
package coi_pkg;

   localparam int DIR_W = 16;
   localparam int VAL_W = 32;
   localparam int SQ_W = 32;
   localparam int LEN_W = 34;
   localparam int NRM_W = 31;
   localparam int ACC_W = 34;
   localparam int MET_W = 17;
   localparam int QUO_STEPS = 31;
   localparam int ROOT_STEPS = 17;

   localparam logic [MET_W-1:0] M100 = 17'd65536;
   localparam logic [MET_W-1:0] M110 = 17'd46341;
   localparam logic [MET_W-1:0] M111 = 17'd37837;
   localparam logic [19:0] RECIP_HI = 20'd223754;
   localparam logic [19:0] RECIP_LO = 20'd505053;
   localparam logic [VAL_W-1:0] ONE_Q16 = 32'd65536;

   localparam int IN_W = 3 * DIR_W + 3 * VAL_W;

   typedef struct packed {
      logic signed [VAL_W-1:0] v100;
      logic signed [VAL_W-1:0] v110;
      logic signed [VAL_W-1:0] v111;
      logic zero;
   } side_type;

   typedef struct packed {
      logic [LEN_W-1:0] rem_x;
      logic [LEN_W-1:0] rem_y;
      logic [LEN_W-1:0] rem_z;
      logic [NRM_W-1:0] q_x;
      logic [NRM_W-1:0] q_y;
      logic [NRM_W-1:0] q_z;
      logic [LEN_W-1:0] len;
      logic [SQ_W-1:0] sx;
      logic [SQ_W-1:0] sy;
      logic [SQ_W-1:0] sz;
   } div_type;

   typedef struct packed {
      logic [ACC_W-1:0] rem;
      logic [MET_W-1:0] root;
      logic [ACC_W-1:0] val;
   } root_type;

endpackage

@@ hw/rtl/coi_div_cell.sv @@
module coi_div_cell #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic enable,
   input  coi_pkg::div_type d_in,
   input  coi_pkg::side_type s_in,
   output logic valid_out,
   output coi_pkg::div_type d_out,
   output coi_pkg::side_type s_out
);
   logic valid_ff;
   coi_pkg::div_type d_ff, d_in_c;
   coi_pkg::side_type s_ff;

   function automatic logic [coi_pkg::LEN_W:0] step_one(
      input logic [coi_pkg::LEN_W-1:0] rem,
      input logic [coi_pkg::SQ_W-1:0] sq,
      input logic [coi_pkg::LEN_W-1:0] len
   );
      logic [coi_pkg::LEN_W:0] t;
      logic bitv;
      begin
         // first cell shifts in the low bit of the square, later cells zeros
         bitv = (STEP == 0) ? sq[0] : 1'b0;
         t = {rem, 1'b0} | {{coi_pkg::LEN_W{1'b0}}, bitv};
         if (t >= {1'b0, len}) begin
            step_one = {t[coi_pkg::LEN_W-1:0] - len, 1'b1};
         end else begin
            step_one = {t[coi_pkg::LEN_W-1:0], 1'b0};
         end
      end
   endfunction

   logic [coi_pkg::LEN_W:0] rx, ry, rz;

   always_comb begin
      rx = step_one(d_in.rem_x, d_in.sx, d_in.len);
      ry = step_one(d_in.rem_y, d_in.sy, d_in.len);
      rz = step_one(d_in.rem_z, d_in.sz, d_in.len);
      d_in_c = d_in;
      d_in_c.rem_x = rx[coi_pkg::LEN_W:1];
      d_in_c.rem_y = ry[coi_pkg::LEN_W:1];
      d_in_c.rem_z = rz[coi_pkg::LEN_W:1];
      d_in_c.q_x = {d_in.q_x[coi_pkg::NRM_W-2:0], rx[0]};
      d_in_c.q_y = {d_in.q_y[coi_pkg::NRM_W-2:0], ry[0]};
      d_in_c.q_z = {d_in.q_z[coi_pkg::NRM_W-2:0], rz[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         d_ff <= d_in_c;
         s_ff <= s_in;
      end
   end

   assign valid_out = valid_ff;
   assign d_out = d_ff;
   assign s_out = s_ff;
endmodule

@@ hw/rtl/coi_root_cell.sv @@
module coi_root_cell (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic enable,
   input  coi_pkg::root_type r_in,
   input  coi_pkg::side_type s_in,
   output logic valid_out,
   output coi_pkg::root_type r_out,
   output coi_pkg::side_type s_out
);
   logic valid_ff;
   coi_pkg::root_type r_ff, r_c;
   coi_pkg::side_type s_ff;
   logic [coi_pkg::ACC_W+1:0] trial, remw;

   always_comb begin
      r_c = r_in;
      remw = {r_in.rem, r_in.val[coi_pkg::ACC_W-1:coi_pkg::ACC_W-2]};
      trial = {{(coi_pkg::ACC_W+2-coi_pkg::MET_W-2){1'b0}}, r_in.root, 2'b01};
      r_c.val = {r_in.val[coi_pkg::ACC_W-3:0], 2'b00};
      if (remw >= trial) begin
         r_c.rem = coi_pkg::ACC_W'(remw - trial);
         r_c.root = {r_in.root[coi_pkg::MET_W-2:0], 1'b1};
      end else begin
         r_c.rem = remw[coi_pkg::ACC_W-1:0];
         r_c.root = {r_in.root[coi_pkg::MET_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         r_ff <= r_c;
         s_ff <= s_in;
      end
   end

   assign valid_out = valid_ff;
   assign r_out = r_ff;
   assign s_out = s_ff;
endmodule

@@ hw/rtl/crystal_orientation_interpolator_top.sv @@
// Fully pipelined orientation interpolator: one beat accepted per clock
// unless stalled. Stages: one squaring stage, 31 restoring divider cells
// (one quotient bit each, all three components side by side), two stages
// for the fourth-power sum, 17 root cells (one result bit each), and four
// stages for segment select, reciprocal scaling, value blend and output.
// The whole chain moves when the output register is empty or being taken.
module crystal_orientation_interpolator_top (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // dir_x, dir_y, dir_z, val_100, val_110, val_111
   input  logic [coi_pkg::IN_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_value
   output logic [coi_pkg::VAL_W-1:0] rsp_tdata,
   // bad_direction
   output logic rsp_tuser
);
   localparam int DW = coi_pkg::DIR_W;
   localparam int VW = coi_pkg::VAL_W;
   localparam int NQ = coi_pkg::QUO_STEPS;
   localparam int NR = coi_pkg::ROOT_STEPS;

   localparam logic [1:0] SEL_V100 = 2'd0;
   localparam logic [1:0] SEL_V111 = 2'd1;
   localparam logic [1:0] SEL_BLEND = 2'd2;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // squaring stage
   logic sq_v_ff;
   coi_pkg::div_type sq_ff, sq_in;
   coi_pkg::side_type sqs_ff, sqs_in;
   logic signed [DW-1:0] dx, dy, dz;
   always_comb begin
      dx = req_tdata[DW-1:0];
      dy = req_tdata[2*DW-1:DW];
      dz = req_tdata[3*DW-1:2*DW];
      sq_in = '0;
      sq_in.sx = coi_pkg::SQ_W'(dx * dx);
      sq_in.sy = coi_pkg::SQ_W'(dy * dy);
      sq_in.sz = coi_pkg::SQ_W'(dz * dz);
      sq_in.len = coi_pkg::LEN_W'(sq_in.sx) + coi_pkg::LEN_W'(sq_in.sy)
         + coi_pkg::LEN_W'(sq_in.sz);
      sqs_in.v100 = req_tdata[3*DW+VW-1:3*DW];
      sqs_in.v110 = req_tdata[3*DW+2*VW-1:3*DW+VW];
      sqs_in.v111 = req_tdata[3*DW+3*VW-1:3*DW+2*VW];
      sqs_in.zero = (sq_in.len == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
      end else if (en) begin
         sq_v_ff <= req_tvalid;
      end
      if (en) begin
         sq_ff <= sq_in;
         sqs_ff <= sqs_in;
      end
   end

   // dividend is sq << 30; top bits of sq feed the first cells
   coi_pkg::div_type dch [0:NQ];
   coi_pkg::side_type dsd [0:NQ];
   logic dv [0:NQ];
   coi_pkg::div_type dseed;
   always_comb begin
      dseed = sq_ff;
      // sq <= len, so sq >> 1 < len; the first cell shifts in the low bit of sq
      dseed.rem_x = coi_pkg::LEN_W'(sq_ff.sx >> 1);
      dseed.rem_y = coi_pkg::LEN_W'(sq_ff.sy >> 1);
      dseed.rem_z = coi_pkg::LEN_W'(sq_ff.sz >> 1);
      if (sq_ff.len == '0) begin
         dseed.len = coi_pkg::LEN_W'(1);
      end
   end
   assign dch[0] = dseed;
   assign dsd[0] = sqs_ff;
   assign dv[0] = sq_v_ff;

   generate
      for (genvar i = 0; i < NQ; i++) begin : g_div
         coi_div_cell #(.STEP(i)) u_cell (
            .clock(clock), .reset(reset), .valid_in(dv[i]), .enable(en),
            .d_in(dch[i]), .s_in(dsd[i]),
            .valid_out(dv[i+1]), .d_out(dch[i+1]), .s_out(dsd[i+1])
         );
      end
   endgenerate

   // fourth-power sum: products then add
   logic p_v_ff, a_v_ff;
   logic [61:0] px_ff, py_ff, pz_ff;
   logic [coi_pkg::ACC_W-1:0] acc_ff;
   coi_pkg::side_type ps_ff, as_ff;
   logic [63:0] psum;
   assign psum = 64'(px_ff) + 64'(py_ff) + 64'(pz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
      end else if (en) begin
         p_v_ff <= dv[NQ];
         a_v_ff <= p_v_ff;
      end
      if (en) begin
         px_ff <= dch[NQ].q_x * dch[NQ].q_x;
         py_ff <= dch[NQ].q_y * dch[NQ].q_y;
         pz_ff <= dch[NQ].q_z * dch[NQ].q_z;
         ps_ff <= dsd[NQ];
         acc_ff <= psum[28+coi_pkg::ACC_W-1:28];
         as_ff <= ps_ff;
      end
   end

   coi_pkg::root_type rch [0:NR];
   coi_pkg::side_type rsd [0:NR];
   logic rv [0:NR];
   assign rch[0] = '{rem: '0, root: '0, val: acc_ff};
   assign rsd[0] = as_ff;
   assign rv[0] = a_v_ff;

   generate
      for (genvar j = 0; j < NR; j++) begin : g_root
         coi_root_cell u_cell (
            .clock(clock), .reset(reset), .valid_in(rv[j]), .enable(en),
            .r_in(rch[j]), .s_in(rsd[j]),
            .valid_out(rv[j+1]), .r_out(rch[j+1]), .s_out(rsd[j+1])
         );
      end
   endgenerate

   // segment select
   logic [coi_pkg::MET_W-1:0] met;
   assign met = rch[NR].root;
   logic g_v_ff, t_v_ff, b_v_ff;
   logic [1:0] g_sel_ff, t_sel_ff, b_sel_ff;
   logic [coi_pkg::MET_W-1:0] g_d_ff;
   logic g_hi_ff;
   coi_pkg::side_type g_s_ff, t_s_ff, b_s_ff;
   logic signed [VW-1:0] t_a_ff, t_b_ff;
   logic [16:0] t_t_ff;
   logic [37:0] dprod;
   logic [21:0] tq;
   logic signed [VW:0] diff;
   logic signed [50:0] bl_in;
   logic signed [50:0] bl_ff;
   logic signed [VW-1:0] b_a_ff;

   assign dprod = 38'(g_d_ff) * 38'(g_hi_ff ? coi_pkg::RECIP_HI : coi_pkg::RECIP_LO);
   assign tq = dprod[37:16];
   assign diff = (VW+1)'(t_b_ff) - (VW+1)'(t_a_ff);
   assign bl_in = 51'(diff) * $signed({1'b0, t_t_ff}) + 51'sd32768;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
         t_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= rv[NR];
         t_v_ff <= g_v_ff;
         b_v_ff <= t_v_ff;
      end
      if (en) begin
         g_s_ff <= rsd[NR];
         if (met >= coi_pkg::M100) begin
            g_sel_ff <= SEL_V100;
         end else if (met <= coi_pkg::M111) begin
            g_sel_ff <= SEL_V111;
         end else begin
            g_sel_ff <= SEL_BLEND;
         end
         g_hi_ff <= met > coi_pkg::M110;
         g_d_ff <= (met > coi_pkg::M110) ? coi_pkg::M100 - met : coi_pkg::M110 - met;
         t_s_ff <= g_s_ff;
         t_sel_ff <= g_sel_ff;
         t_a_ff <= g_hi_ff ? g_s_ff.v100 : g_s_ff.v110;
         t_b_ff <= g_hi_ff ? g_s_ff.v110 : g_s_ff.v111;
         t_t_ff <= (tq > 22'd65536) ? 17'd65536 : tq[16:0];
         b_s_ff <= t_s_ff;
         b_sel_ff <= t_sel_ff;
         b_a_ff <= t_a_ff;
         bl_ff <= bl_in;
      end
   end

   logic [VW-1:0] res;
   always_comb begin
      if (b_s_ff.zero) begin
         res = coi_pkg::ONE_Q16;
      end else begin
         case (b_sel_ff)
            SEL_V100: res = b_s_ff.v100;
            SEL_V111: res = b_s_ff.v111;
            default: res = VW'(b_a_ff + VW'(bl_ff >>> 16));
         endcase
      end
   end

   logic o_v_ff;
   logic [VW-1:0] o_d_ff;
   logic o_u_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= b_v_ff;
      end
      if (en) begin
         o_d_ff <= res;
         o_u_ff <= b_s_ff.zero;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata = o_d_ff;
   assign rsp_tuser = o_u_ff;

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready)) else $error("ready mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == coi_pkg::ONE_Q16)
      else $error("bad direction value");
`endif
endmodule

@@ verif/crystal_orientation_interpolator_top_tb.sv @@
`timescale 1ns / 100ps

module crystal_orientation_interpolator_top_tb;

   typedef struct {
      logic signed [coi_pkg::DIR_W-1:0] dx;
      logic signed [coi_pkg::DIR_W-1:0] dy;
      logic signed [coi_pkg::DIR_W-1:0] dz;
      logic signed [coi_pkg::VAL_W-1:0] v100;
      logic signed [coi_pkg::VAL_W-1:0] v110;
      logic signed [coi_pkg::VAL_W-1:0] v111;
   } probe_type;

   typedef struct {
      logic [coi_pkg::VAL_W-1:0] value;
      logic bad;
   } blend_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [coi_pkg::IN_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [coi_pkg::VAL_W-1:0] rsp_tdata;
   logic rsp_tuser;

   probe_type pending_probes[$];
   blend_type expected_blends[$];
   int errors;
   int send_gap;
   int take_gap;
   bit stim_done;

   crystal_orientation_interpolator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint blend_segment(longint a, longint b, longint unsigned d,
                                            longint unsigned recip);
      longint unsigned t;
      longint prod;
      longint q;
      t = (d * recip) >> 16;
      if (t > 65536) t = 65536;
      prod = (b - a) * longint'(t) + 32768;
      if (prod >= 0) q = longint'(unsigned'(prod) >> 16);
      else q = -longint'((unsigned'(-prod) + 65535) >> 16);
      return a + q;
   endfunction

   function automatic blend_type orientation_blend(probe_type p);
      blend_type r;
      longint unsigned sx, sy, sz, len, nx, ny, nz, acc, m;
      longint res;
      sx = longint'(p.dx) * longint'(p.dx);
      sy = longint'(p.dy) * longint'(p.dy);
      sz = longint'(p.dz) * longint'(p.dz);
      len = sx + sy + sz;
      if (len == 0) begin
         r.value = coi_pkg::ONE_Q16;
         r.bad = 1'b1;
         return r;
      end
      nx = (sx << 30) / len;
      ny = (sy << 30) / len;
      nz = (sz << 30) / len;
      acc = (nx * nx + ny * ny + nz * nz) >> 28;
      m = int_sqrt(acc);
      if (m >= coi_pkg::M100) res = p.v100;
      else if (m <= coi_pkg::M111) res = p.v111;
      else if (m > coi_pkg::M110)
         res = blend_segment(p.v100, p.v110, coi_pkg::M100 - m, coi_pkg::RECIP_HI);
      else res = blend_segment(p.v110, p.v111, coi_pkg::M110 - m, coi_pkg::RECIP_LO);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.value = res[31:0];
      r.bad = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 400000)) - 200000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7fff;
         2: return 16'h8000;
         3: return 16'(int'($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_probe(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [31:0] a, logic [31:0] b, logic [31:0] c);
      probe_type p;
      p.dx = x;
      p.dy = y;
      p.dz = z;
      p.v100 = a;
      p.v110 = b;
      p.v111 = c;
      pending_probes.push_back(p);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      logic [15:0] s;
      logic [15:0] x;
      logic [15:0] y;
      // directed: zero, axes, diagonals, extremes, near segment points
      add_probe(0, 0, 0, 32'h12345678, 1, 2);
      add_probe(16'h4000, 0, 0, 32'h7fffffff, 0, 32'h80000000);
      add_probe(0, 16'h8000, 0, 100, 200, 300);
      add_probe(0, 0, 16'h7fff, 100, 200, 300);
      add_probe(16'h4000, 16'h4000, 0, 100, 200, 300);
      add_probe(16'h8000, 16'h8000, 0, 32'h7fffffff, 32'h80000000, 0);
      add_probe(16'h4000, 16'h4000, 16'h4000, 100, 200, 300);
      add_probe(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 0, 32'h7fffffff);
      add_probe(16'h7fff, 16'h8000, 16'h7fff, 1, 2, 3);
      add_probe(16'h4000, 16'h2000, 0, 32'h80000000, 32'h7fffffff, 0);
      add_probe(16'h4000, 16'h3000, 16'h1000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      add_probe(16'h4000, 16'h4000, 16'h2000, 32'h80000000, 32'h7fffffff, 32'h80000000);
      add_probe(16'h0001, 0, 0, 5, 6, 7);
      add_probe(16'hffff, 16'h0001, 0, 5, 6, 7);
      add_probe(16'h0001, 16'hffff, 16'h0001, 5, 6, 7);
      add_probe(16'h7000, 16'h1000, 16'h0800, -65536, 65536, 0);
      add_probe(16'h3000, 16'h2800, 16'h2000, -65536, 65536, 0);
      add_probe(16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      for (int i = 0; i < 1340; i++) begin
         if (i % 3 == 0) begin
            // direction near a chosen orientation with small perturbation
            s = 16'($urandom_range(1, 16383));
            x = s;
            y = (i % 2) ? s : 16'(s >> $urandom_range(0, 4));
            add_probe(16'(x + 16'($urandom_range(0, 64)) - 16'd32),
                      ($urandom_range(0, 1) ? y : -y),
                      16'($urandom_range(0, 1) ? s >> $urandom_range(0, 6) : 0),
                      rand_val(), rand_val(), rand_val());
         end else begin
            add_probe(rand_dir(), rand_dir(), rand_dir(), rand_val(), rand_val(), rand_val());
         end
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_blends.push_back(orientation_blend(pending_probes.pop_front()));
         if (send_gap > 0 || pending_probes.size() == 0) begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
            else stim_done <= 1'b1;
         end else begin
            probe_type p;
            p = pending_probes[0];
            req_tvalid <= 1'b1;
            req_tdata <= {p.v111, p.v110, p.v100, p.dz, p.dy, p.dx};
            send_gap <= pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blends.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, 0);
            end else begin
               blend_type e;
               e = expected_blends.pop_front();
               if (rsp_tdata !== e.value) report_mismatch("result_value", rsp_tdata, e.value);
               if (rsp_tuser !== e.bad) report_mismatch("bad_direction", rsp_tuser, e.bad);
            end
         end
         if (take_gap > 0) begin
            rsp_tready <= 1'b0;
            take_gap <= take_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            take_gap <= pick_gap();
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && !req_tvalid && expected_blends.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_blends.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/coi_pkg.sv
hw/rtl/coi_div_cell.sv
hw/rtl/coi_root_cell.sv
hw/rtl/crystal_orientation_interpolator_top.sv
verif/crystal_orientation_interpolator_top_tb.sv
